@@ src/jstp_pkg.sv @@
// Shared types, codes and character helpers for the JSON scalar token parser.
package jstp_pkg;

    // Parser phase, one-hot coded.
    typedef enum logic [13:0] {
        PH_LEAD    = 14'b00_0000_0000_0001,
        PH_LIT     = 14'b00_0000_0000_0010,
        PH_SIGN    = 14'b00_0000_0000_0100,
        PH_ZERO    = 14'b00_0000_0000_1000,
        PH_INT     = 14'b00_0000_0001_0000,
        PH_DOT     = 14'b00_0000_0010_0000,
        PH_FRAC    = 14'b00_0000_0100_0000,
        PH_EXP     = 14'b00_0000_1000_0000,
        PH_EXPSIGN = 14'b00_0001_0000_0000,
        PH_EXPDIG  = 14'b00_0010_0000_0000,
        PH_STR     = 14'b00_0100_0000_0000,
        PH_ESC     = 14'b00_1000_0000_0000,
        PH_TRAIL   = 14'b01_0000_0000_0000,
        PH_ERR     = 14'b10_0000_0000_0000
    } phase_t;

    // Verdict status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EXPECT  = 2'd1,
        ST_INVALID = 2'd2,
        ST_NOTSING = 2'd3
    } status_t;

    // Value type codes.
    typedef enum logic [2:0] {
        TY_NULL   = 3'd0,
        TY_FALSE  = 3'd1,
        TY_TRUE   = 3'd2,
        TY_NUMBER = 3'd3,
        TY_STRING = 3'd4
    } vtype_t;

    // Literal selector.
    typedef enum logic [1:0] {
        LIT_NULL  = 2'd0,
        LIT_TRUE  = 2'd1,
        LIT_FALSE = 2'd2
    } lit_t;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        phase_t     phase;
        lit_t       lit_kind;
        logic [2:0] lit_pos;
        status_t    held_status;
        vtype_t     held_type;
    } pstate_t;

    // One result beat plus its presence flag.
    typedef struct packed {
        logic       emit;
        logic       is_verdict;
        logic [7:0] char_out;
        status_t    status;
        vtype_t     value_type;
    } result_t;

    // Whitespace set of the JSON grammar.
    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Expected byte of a literal at a given position.
    function automatic logic [7:0] lit_char(input lit_t k, input logic [2:0] p);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            LIT_NULL:
            begin
                case (p)
                    3'd0: r = "n";
                    3'd1: r = "u";
                    3'd2: r = "l";
                    3'd3: r = "l";
                    default: r = 8'h00;
                endcase
            end
            LIT_TRUE:
            begin
                case (p)
                    3'd0: r = "t";
                    3'd1: r = "r";
                    3'd2: r = "u";
                    3'd3: r = "e";
                    default: r = 8'h00;
                endcase
            end
            LIT_FALSE:
            begin
                case (p)
                    3'd0: r = "f";
                    3'd1: r = "a";
                    3'd2: r = "l";
                    3'd3: r = "s";
                    3'd4: r = "e";
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lit_len(input lit_t k);
        lit_len = (k == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic vtype_t lit_type(input lit_t k);
        vtype_t t;
        case (k)
            LIT_TRUE:  t = TY_TRUE;
            LIT_FALSE: t = TY_FALSE;
            default:   t = TY_NULL;
        endcase
        return t;
    endfunction

endpackage

@@ src/json_scalar_token_parser.sv @@
// Top level of the JSON scalar token parser: state and result registers.
//
// Usage: text bytes enter on the input channel (ch, in_valid, in_ready); a
// zero byte ends the text. Result beats leave on the output channel
// (out_valid, out_ready) with is_verdict, char_out, status and value_type.
// A string content beat (is_verdict 0) is sent for each unescaped string
// byte; it is provisional until the verdict beat confirms the string.
// The verdict beat (is_verdict 1) follows the end byte and the parser is
// then ready for the next text at once.
// A result beat is registered and valid in the cycle after its byte is taken.
// Throughput: one byte per cycle; the byte is decoded by a single level of
// compare logic against the phase register, feeding the result register.
// When the receiver stalls, the result register holds its beat and the
// input takes no new byte until that beat leaves; bytes that produce no
// beat are still taken only when the result register is free or draining.
// Reset: the parser returns to awaiting leading whitespace with no error
// held, and the result register is emptied.
module json_scalar_token_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_verdict,
    output logic [7:0] char_out,
    output logic [1:0] status,
    output logic [2:0] value_type
);
    import jstp_pkg::*;

    pstate_t    state_reg;
    pstate_t    state_next;
    result_t    step_res;
    logic       out_valid_reg;
    logic       is_verdict_reg;
    logic [7:0] char_out_reg;
    status_t    status_reg;
    vtype_t     value_type_reg;
    logic       accept;

    // Decode of the current byte.
    jstp_step u_step
    (
        .cur (state_reg),
        .ch  (ch),
        .nxt (state_next),
        .res (step_res)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_LEAD;
            state_reg.lit_kind    <= LIT_NULL;
            state_reg.lit_pos     <= 3'd0;
            state_reg.held_status <= ST_OK;
            state_reg.held_type   <= TY_NULL;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= step_res.emit;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload, loaded when a beat is produced.
    always_ff @(posedge clk)
    begin
        if (accept && step_res.emit)
        begin
            is_verdict_reg <= step_res.is_verdict;
            char_out_reg   <= step_res.char_out;
            status_reg     <= step_res.status;
            value_type_reg <= step_res.value_type;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_verdict = is_verdict_reg;
    assign char_out   = char_out_reg;
    assign status     = status_reg;
    assign value_type = value_type_reg;

endmodule

@@ src/jstp_step.sv @@
// Next-state and result logic of the parser for one input byte.
module jstp_step
(
    input  jstp_pkg::pstate_t cur,
    input  logic [7:0]        ch,
    output jstp_pkg::pstate_t nxt,
    output jstp_pkg::result_t res
);
    import jstp_pkg::*;

    logic [7:0] esc_byte;
    logic       esc_known;
    logic [2:0] pos_inc;

    // Escape translation.
    always_comb
    begin
        esc_known = 1'b1;
        case (ch)
            "n":     esc_byte = 8'h0A;
            "\"":    esc_byte = 8'h22;
            "\\":    esc_byte = 8'h5C;
            "b":     esc_byte = 8'h08;
            "r":     esc_byte = 8'h0D;
            "t":     esc_byte = 8'h09;
            "f":     esc_byte = 8'h0C;
            "/":     esc_byte = 8'h2F;
            default:
            begin
                esc_byte  = 8'h00;
                esc_known = 1'b0;
            end
        endcase
    end

    assign pos_inc = cur.lit_pos + 3'd1;

    // Phase transitions and the result beat.
    always_comb
    begin
        nxt = cur;
        res = '0;
        if (ch == 8'h00)
        begin
            // End byte: verdict, then clear for the next text.
            res.emit       = 1'b1;
            res.is_verdict = 1'b1;
            res.value_type = TY_NULL;
            case (cur.phase)
                PH_LEAD, PH_STR, PH_ESC:
                    res.status = ST_EXPECT;
                PH_LIT, PH_SIGN, PH_DOT, PH_EXP, PH_EXPSIGN:
                    res.status = ST_INVALID;
                PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG:
                begin
                    res.status     = ST_OK;
                    res.value_type = TY_NUMBER;
                end
                PH_TRAIL:
                begin
                    res.status     = ST_OK;
                    res.value_type = cur.held_type;
                end
                default:
                    res.status = cur.held_status;
            endcase
            nxt.phase       = PH_LEAD;
            nxt.lit_kind    = LIT_NULL;
            nxt.lit_pos     = 3'd0;
            nxt.held_status = ST_OK;
            nxt.held_type   = TY_NULL;
        end
        else
        begin
            case (cur.phase)
                PH_LEAD:
                begin
                    if (is_ws(ch))
                        nxt.phase = PH_LEAD;
                    else if (ch == "n" || ch == "t" || ch == "f")
                    begin
                        nxt.lit_kind = (ch == "n") ? LIT_NULL :
                                       (ch == "t") ? LIT_TRUE : LIT_FALSE;
                        nxt.lit_pos  = 3'd1;
                        nxt.phase    = PH_LIT;
                    end
                    else if (ch == "\"")
                        nxt.phase = PH_STR;
                    else if (ch == "-")
                        nxt.phase = PH_SIGN;
                    else if (ch == "0")
                        nxt.phase = PH_ZERO;
                    else if (is_digit(ch))
                        nxt.phase = PH_INT;
                    else
                    begin
                        nxt.held_status = ST_INVALID;
                        nxt.held_type   = TY_NULL;
                        nxt.phase       = PH_ERR;
                    end
                end
                PH_LIT:
                begin
                    if (cur.lit_pos == 3'd0 || cur.lit_pos >= lit_len(cur.lit_kind) ||
                        lit_char(cur.lit_kind, cur.lit_pos) != ch)
                    begin
                        nxt.held_status = ST_INVALID;
                        nxt.held_type   = TY_NULL;
                        nxt.phase       = PH_ERR;
                    end
                    else
                    begin
                        nxt.lit_pos = pos_inc;
                        if (pos_inc >= lit_len(cur.lit_kind))
                        begin
                            nxt.held_type = lit_type(cur.lit_kind);
                            nxt.phase     = PH_TRAIL;
                        end
                    end
                end
                PH_SIGN:
                begin
                    if (ch == "0")
                        nxt.phase = PH_ZERO;
                    else if (is_digit(ch))
                        nxt.phase = PH_INT;
                    else
                    begin
                        nxt.held_status = ST_INVALID;
                        nxt.held_type   = TY_NULL;
                        nxt.phase       = PH_ERR;
                    end
                end
                PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG:
                begin
                    // Digit runs continue; otherwise the number may move on or end.
                    if (is_digit(ch) && cur.phase != PH_ZERO)
                        nxt.phase = cur.phase;
                    else if (ch == "." && (cur.phase == PH_ZERO || cur.phase == PH_INT))
                        nxt.phase = PH_DOT;
                    else if ((ch == "e" || ch == "E") && cur.phase != PH_EXPDIG)
                        nxt.phase = PH_EXP;
                    else
                    begin
                        nxt.held_type = TY_NUMBER;
                        if (is_ws(ch))
                            nxt.phase = PH_TRAIL;
                        else
                        begin
                            nxt.held_status = ST_NOTSING;
                            nxt.held_type   = TY_NULL;
                            nxt.phase       = PH_ERR;
                        end
                    end
                end
                PH_DOT:
                begin
                    if (is_digit(ch))
                        nxt.phase = PH_FRAC;
                    else
                    begin
                        nxt.held_status = ST_INVALID;
                        nxt.held_type   = TY_NULL;
                        nxt.phase       = PH_ERR;
                    end
                end
                PH_EXP:
                begin
                    if (ch == "+" || ch == "-")
                        nxt.phase = PH_EXPSIGN;
                    else if (is_digit(ch))
                        nxt.phase = PH_EXPDIG;
                    else
                    begin
                        nxt.held_status = ST_INVALID;
                        nxt.held_type   = TY_NULL;
                        nxt.phase       = PH_ERR;
                    end
                end
                PH_EXPSIGN:
                begin
                    if (is_digit(ch))
                        nxt.phase = PH_EXPDIG;
                    else
                    begin
                        nxt.held_status = ST_INVALID;
                        nxt.held_type   = TY_NULL;
                        nxt.phase       = PH_ERR;
                    end
                end
                PH_STR:
                begin
                    if (ch == "\"")
                    begin
                        nxt.held_type = TY_STRING;
                        nxt.phase     = PH_TRAIL;
                    end
                    else if (ch == "\\")
                        nxt.phase = PH_ESC;
                    else
                    begin
                        res.emit     = 1'b1;
                        res.char_out = ch;
                    end
                end
                PH_ESC:
                begin
                    // Unknown escapes are dropped silently.
                    nxt.phase    = PH_STR;
                    res.emit     = esc_known;
                    res.char_out = esc_byte;
                end
                PH_TRAIL:
                begin
                    if (!is_ws(ch))
                    begin
                        nxt.held_status = ST_NOTSING;
                        nxt.held_type   = TY_NULL;
                        nxt.phase       = PH_ERR;
                    end
                end
                default:
                    nxt.phase = cur.phase;
            endcase
        end
    end

endmodule

@@ tb/tb_json_scalar_token_parser.sv @@
// Self-checking testbench for the JSON scalar token parser.
module tb_json_scalar_token_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import jstp_pkg::*;

    localparam int         STALL_LIMIT  = 2000;
    localparam int         LONG_HOLD    = 300;
    localparam int         TAIL_CYCLES  = 8;
    localparam int         RANDOM_BYTES = 560;
    localparam int         PRINT_CAP    = 30;
    localparam logic [7:0] END_BYTE     = 8'h00;
    localparam logic [7:0] QUOTE        = 8'h22;
    localparam logic [7:0] BSLASH       = 8'h5C;

    // One result beat as the parser should send it.
    typedef struct {
        logic       is_v;
        logic [7:0] chr;
        status_t    st;
        vtype_t     ty;
    } parse_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ch = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       is_verdict;
    logic [7:0] char_out;
    logic [1:0] status;
    logic [2:0] value_type;

    logic [7:0]  pending_bytes[$];
    logic [7:0]  text_buf[$];
    parse_beat_t expected_beats[$];
    int          err_count = 0;
    int          beat_count = 0;
    logic        in_taken = 1'b0;
    logic        hold_req = 1'b0;

    // Parser state mirrored by the predictor.
    phase_t  ph = PH_LEAD;
    lit_t    lk = LIT_NULL;
    int      lpos = 0;
    status_t held_st = ST_OK;
    vtype_t  held_ty = TY_NULL;

    json_scalar_token_parser DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_verdict (is_verdict),
        .char_out   (char_out),
        .status     (status),
        .value_type (value_type)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic space_char(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic string literal_word(input lit_t k);
        case (k)
            LIT_TRUE:  return "true";
            LIT_FALSE: return "false";
            default:   return "null";
        endcase
    endfunction

    task automatic push_beat(input logic v, input logic [7:0] c, input status_t s,
                             input vtype_t t);
        parse_beat_t b;
        b.is_v = v;
        b.chr  = c;
        b.st   = s;
        b.ty   = t;
        expected_beats.push_back(b);
    endtask

    task automatic parse_fail(input status_t s);
        held_st = s;
        held_ty = TY_NULL;
        ph      = PH_ERR;
    endtask

    // A number ended just before a nonzero byte.
    task automatic number_end(input logic [7:0] c);
        held_ty = TY_NUMBER;
        if (space_char(c))
            ph = PH_TRAIL;
        else
            parse_fail(ST_NOTSING);
    endtask

    // Advance the mirrored parser by one accepted byte and queue its beat, if any.
    task automatic parse_byte(input logic [7:0] c);
        status_t    s;
        vtype_t     t;
        string      w;
        logic [7:0] e;
        if (c == END_BYTE)
        begin
            t = TY_NULL;
            case (ph)
                PH_LEAD, PH_STR, PH_ESC: s = ST_EXPECT;
                PH_LIT, PH_SIGN, PH_DOT, PH_EXP, PH_EXPSIGN: s = ST_INVALID;
                PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG:
                begin
                    s = ST_OK;
                    t = TY_NUMBER;
                end
                PH_TRAIL:
                begin
                    s = ST_OK;
                    t = held_ty;
                end
                default: s = held_st;
            endcase
            push_beat(1'b1, 8'h00, s, t);
            ph      = PH_LEAD;
            lk      = LIT_NULL;
            lpos    = 0;
            held_st = ST_OK;
            held_ty = TY_NULL;
        end
        else
        begin
            case (ph)
                PH_LEAD:
                begin
                    if (space_char(c))
                        ph = PH_LEAD;
                    else if (c == "n" || c == "t" || c == "f")
                    begin
                        lk   = (c == "n") ? LIT_NULL : (c == "t") ? LIT_TRUE : LIT_FALSE;
                        lpos = 1;
                        ph   = PH_LIT;
                    end
                    else if (c == QUOTE)
                        ph = PH_STR;
                    else if (c == "-")
                        ph = PH_SIGN;
                    else if (c == "0")
                        ph = PH_ZERO;
                    else if (digit_char(c))
                        ph = PH_INT;
                    else
                        parse_fail(ST_INVALID);
                end
                PH_LIT:
                begin
                    w = literal_word(lk);
                    if (c != w[lpos])
                        parse_fail(ST_INVALID);
                    else
                    begin
                        lpos++;
                        if (lpos >= w.len())
                        begin
                            held_ty = (lk == LIT_TRUE) ? TY_TRUE :
                                      (lk == LIT_FALSE) ? TY_FALSE : TY_NULL;
                            ph = PH_TRAIL;
                        end
                    end
                end
                PH_SIGN:
                begin
                    if (c == "0")
                        ph = PH_ZERO;
                    else if (digit_char(c))
                        ph = PH_INT;
                    else
                        parse_fail(ST_INVALID);
                end
                PH_ZERO, PH_INT:
                begin
                    if (ph == PH_INT && digit_char(c))
                        ph = PH_INT;
                    else if (c == ".")
                        ph = PH_DOT;
                    else if (c == "e" || c == "E")
                        ph = PH_EXP;
                    else
                        number_end(c);
                end
                PH_DOT:
                begin
                    if (digit_char(c))
                        ph = PH_FRAC;
                    else
                        parse_fail(ST_INVALID);
                end
                PH_FRAC:
                begin
                    if (c == "e" || c == "E")
                        ph = PH_EXP;
                    else if (!digit_char(c))
                        number_end(c);
                end
                PH_EXP:
                begin
                    if (c == "+" || c == "-")
                        ph = PH_EXPSIGN;
                    else if (digit_char(c))
                        ph = PH_EXPDIG;
                    else
                        parse_fail(ST_INVALID);
                end
                PH_EXPSIGN:
                begin
                    if (digit_char(c))
                        ph = PH_EXPDIG;
                    else
                        parse_fail(ST_INVALID);
                end
                PH_EXPDIG:
                begin
                    if (!digit_char(c))
                        number_end(c);
                end
                PH_STR:
                begin
                    if (c == QUOTE)
                    begin
                        held_ty = TY_STRING;
                        ph = PH_TRAIL;
                    end
                    else if (c == BSLASH)
                        ph = PH_ESC;
                    else
                        push_beat(1'b0, c, ST_OK, TY_NULL);
                end
                PH_ESC:
                begin
                    ph = PH_STR;
                    e  = 8'h00;
                    case (c)
                        "n":    e = 8'h0A;
                        QUOTE:  e = QUOTE;
                        BSLASH: e = BSLASH;
                        "b":    e = 8'h08;
                        "r":    e = 8'h0D;
                        "t":    e = 8'h09;
                        "f":    e = 8'h0C;
                        "/":    e = "/";
                        default: e = 8'h00;
                    endcase
                    // Unknown escapes are dropped without a beat.
                    if (e != 8'h00)
                        push_beat(1'b0, e, ST_OK, TY_NULL);
                end
                PH_TRAIL:
                begin
                    if (!space_char(c))
                        parse_fail(ST_NOTSING);
                end
                default: ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("[%0t] beat %0d %s: got 0x%0h, expected 0x%0h",
                     $realtime, beat_count, what, got, want);
    endtask

    // Output check first, then the byte taken on this edge feeds the predictor.
    always @(posedge clk)
    begin : monitor_blk
        parse_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", char_out, 0);
            else
            begin
                want = expected_beats.pop_front();
                if (is_verdict !== want.is_v)
                    report_mismatch("is_verdict", is_verdict, want.is_v);
                if (char_out !== want.chr)
                    report_mismatch("char_out", char_out, want.chr);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (value_type !== want.ty)
                    report_mismatch("value_type", value_type, want.ty);
            end
            beat_count++;
        end
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
            parse_byte(ch);
    end

    // Sender: bursts of bytes separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin : driver_blk
        logic       nv;
        logic [7:0] nc;
        if (rst_n)
        begin
            nv = in_valid;
            nc = ch;
            if (!in_valid || in_taken)
            begin
                nv = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_bytes.size() > 0)
                begin
                    nc = pending_bytes.pop_front();
                    nv = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            in_valid <= nv;
            ch       <= nc;
        end
    end

    // Receiver: a rotating ready mask, plus one long hold-off on request.
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          mask_age = 0;
    logic [15:0] ready_mask = 16'hFFFF;
    always @(negedge clk)
    begin : receiver_blk
        logic rdy;
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (mask_age == 0)
                begin
                    ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom());
                    mask_age = 48;
                end
                mask_age--;
                rdy = ready_mask[0];
                ready_mask = {ready_mask[0], ready_mask[15:1]};
            end
            out_ready <= rdy;
        end
    end

    // Cycles with work outstanding but no beat moving on either side.
    initial
    begin : watchdog_blk
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (pending_bytes.size() == 0 && !in_valid && expected_beats.size() == 0))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
        pending_bytes.push_back(END_BYTE);
    endtask

    function automatic logic [7:0] random_ws();
        case ($urandom_range(0, 3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    // A well-formed number with random shape.
    task automatic build_number();
        if ($urandom_range(0, 1))
            text_buf.push_back("-");
        if ($urandom_range(0, 3) == 0)
            text_buf.push_back("0");
        else
        begin
            text_buf.push_back(8'h30 + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(0, 3)) text_buf.push_back(random_digit());
        end
        if ($urandom_range(0, 1))
        begin
            text_buf.push_back(".");
            repeat ($urandom_range(1, 3)) text_buf.push_back(random_digit());
        end
        if ($urandom_range(0, 2) == 0)
        begin
            text_buf.push_back($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0:       text_buf.push_back("+");
                1:       text_buf.push_back("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) text_buf.push_back(random_digit());
        end
    endtask

    // A well-formed string with random bytes and escapes.
    task automatic build_string();
        string      esc_set;
        logic [7:0] b;
        esc_set = "n\"\\brtf/";
        text_buf.push_back(QUOTE);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                text_buf.push_back(BSLASH);
                if ($urandom_range(0, 4) == 0)
                    text_buf.push_back(8'($urandom_range(1, 255)));
                else
                    text_buf.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
            end
            else
            begin
                b = 8'($urandom_range(1, 255));
                text_buf.push_back((b == QUOTE || b == BSLASH) ? 8'h41 : b);
            end
        end
        text_buf.push_back(QUOTE);
    endtask

    // One random text: mostly well formed, some broken or pure noise.
    task automatic build_text();
        string w;
        int    pos;
        text_buf.delete();
        repeat ($urandom_range(0, 2)) text_buf.push_back(random_ws());
        case ($urandom_range(0, 2))
            0:
            begin
                w = literal_word(lit_t'($urandom_range(0, 2)));
                for (int i = 0; i < w.len(); i++)
                    text_buf.push_back(w[i]);
            end
            1:       build_number();
            default: build_string();
        endcase
        repeat ($urandom_range(0, 2)) text_buf.push_back(random_ws());
        if ($urandom_range(0, 4) == 0)
        begin
            pos = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: text_buf[pos] = 8'($urandom_range(1, 255));
                1: text_buf = text_buf[0:pos];
                2:
                begin
                    text_buf.delete();
                    repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(1, 255)));
                end
                default:
                begin
                    text_buf.push_back(" ");
                    repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
        foreach (text_buf[i])
            pending_bytes.push_back(text_buf[i]);
        pending_bytes.push_back(END_BYTE);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus_blk
        int pushed;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts: empty and blank, each literal, number forms and their
        // missing digits, escapes, raw control and high bytes, unterminated
        // strings and trailing junk.
        push_text("");
        push_text(" \t\n\r");
        push_text("null");
        push_text(" true ");
        push_text("false");
        push_text("nul");
        push_text("nulx");
        push_text("tRue");
        push_text("-0");
        push_text("9870");
        push_text("-1.5e+10");
        push_text("0.25E-3 ");
        push_text("012");
        push_text("-");
        push_text("1.");
        push_text("1e");
        push_text("-a");
        push_text("5x");
        push_text("\"a\\n\\\"\\\\\\b\\r\\t\\f\\/\\q\"");
        pending_bytes.push_back(QUOTE);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(QUOTE);
        pending_bytes.push_back(END_BYTE);
        push_text("\"abc");
        push_text("\"ab\\");
        push_text("?x null");
        push_text(" true x");
        push_text("\"s\" \t");

        // Sender stops here until every beat of the directed part is back.
        wait_drained();

        // Random texts; the receiver holds off once at the start of this part.
        pushed = 0;
        while (pushed < RANDOM_BYTES)
        begin
            build_text();
            pushed += text_buf.size() + 1;
        end
        hold_req = 1'b1;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/jstp_pkg.sv
src/jstp_step.sv
src/json_scalar_token_parser.sv
tb/tb_json_scalar_token_parser.sv
